### hw/rtl/wmv_pkg.sv
// ----------------------------------------------------------------------------
// wmv_pkg
// Shared widths, constants and control structs of the weighted mean and
// variance core.
// ----------------------------------------------------------------------------
package wmv_pkg;

    localparam int MAX_PAIRS = 1024;
    localparam int ADDR_W    = $clog2(MAX_PAIRS);
    localparam int CNT_W     = ADDR_W + 1;

    localparam int WEIGHT_W  = 16;
    localparam int VALUE_W   = 16;
    localparam int PAIR_W    = WEIGHT_W + VALUE_W;
    localparam int PROD_W    = WEIGHT_W + VALUE_W;
    localparam int SUM_W     = PROD_W + CNT_W;
    localparam int TOTAL_W   = WEIGHT_W + CNT_W;
    localparam int SQ_W      = 2 * VALUE_W;
    localparam int WSQ_W     = WEIGHT_W + SQ_W;
    localparam int ACC_W     = WSQ_W + CNT_W;

    localparam int DIV_N_W   = ACC_W;
    localparam int DIV_D_W   = TOTAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam int MEAN_W    = 16;
    localparam int VAR_W     = 48;
    localparam int FRAC_W    = 16;

    localparam logic [MEAN_W-1:0] MEAN_POS_MAX = 16'h7fff;
    localparam logic [MEAN_W-1:0] MEAN_NEG_MAX = 16'h8000;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [PAIR_W-1:0]    data;
    } store_wr_t;

    typedef struct packed {
        logic                 start;
        logic [CNT_W-1:0]     count;
        logic [MEAN_W-1:0]    mean;
    } pass_cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_N_W-1:0]   dividend;
        logic [DIV_D_W-1:0]   divisor;
    } div_cmd_t;

endpackage

### hw/rtl/wmv_if.sv
// ----------------------------------------------------------------------------
// wmv_if
// Valid/ready stream interfaces for the pair input and the result output.
// ----------------------------------------------------------------------------
interface wmv_in_if
    import wmv_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic [WEIGHT_W-1:0]        weight;
    logic signed [VALUE_W-1:0]  sample_value;
    logic                       last_pair;

    modport source (output valid, output weight, output sample_value, output last_pair,
                    input ready);
    modport sink   (input valid, input weight, input sample_value, input last_pair,
                    output ready);
endinterface

interface wmv_out_if
    import wmv_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic signed [MEAN_W-1:0]   mean;
    logic [VAR_W-1:0]           variance;
    logic                       zero_total;
    logic                       overflow;

    modport source (output valid, output mean, output variance, output zero_total,
                    output overflow, input ready);
    modport sink   (input valid, input mean, input variance, input zero_total,
                    input overflow, output ready);
endinterface

### hw/rtl/wmv_divider.sv
// ----------------------------------------------------------------------------
// wmv_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wmv_divider
    import wmv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_cmd_t           cmd,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;

    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[DIV_N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            num_reg <= cmd.dividend;
            den_reg <= cmd.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_N_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### hw/rtl/wmv_pass.sv
// ----------------------------------------------------------------------------
// wmv_pass
// Pair store and the pipelined walk that sums w * (v - mean)^2.
// ----------------------------------------------------------------------------
module wmv_pass
    import wmv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_wr_t        wr,
    input  pass_cmd_t        cmd,
    output logic             done,
    output logic [ACC_W-1:0] acc
);

    logic [PAIR_W-1:0] mem [MAX_PAIRS];

    logic                      busy_reg;
    logic [CNT_W-1:0]          addr_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic                      s1_vld_reg;
    logic                      s2_vld_reg;
    logic                      s3_vld_reg;
    logic [PAIR_W-1:0]         rd_data_reg;
    logic [WEIGHT_W-1:0]       w1_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [WSQ_W-1:0]          wsq_reg;
    logic [ACC_W-1:0]          acc_reg;

    logic                      issue;
    logic signed [VALUE_W-1:0] rd_value;
    logic signed [VALUE_W:0]   diff;
    logic signed [2*VALUE_W+1:0] sq_full;

    assign issue    = busy_reg && (addr_reg < count_reg);
    assign rd_value = rd_data_reg[VALUE_W-1:0];
    assign diff     = $signed({rd_value[VALUE_W-1], rd_value})
                    - $signed({mean_reg[MEAN_W-1], mean_reg});
    assign sq_full  = diff * diff;
    assign done     = busy_reg && !issue && !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[addr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            addr_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                addr_reg <= '0;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            count_reg <= cmd.count;
            mean_reg  <= cmd.mean;
            acc_reg   <= '0;
        end
        else if (s3_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(wsq_reg);
        end
        w1_reg  <= rd_data_reg[PAIR_W-1:VALUE_W];
        sq_reg  <= sq_full[SQ_W-1:0];
        wsq_reg <= w1_reg * sq_reg;
    end

    assign acc = acc_reg;

endmodule

### hw/rtl/weighted_mean_variance_core.sv
// ----------------------------------------------------------------------------
// weighted_mean_variance_core
// Buffers (weight, value) pairs, then computes the weighted mean and, in a
// second step, a walk over the store, the weighted variance of the data set.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      beat payload
//  samples   in   valid/ready    weight, sample_value, last_pair
//  results   out  valid/ready    mean, variance, zero_total, overflow
//  cfg       in   cfg_write      cfg_data -> mode_cfg_reg
//
//  pairs load at one beat per cycle while samples.ready is high into a
//  1-port-write, 1-port-read store; after the last beat come the S_FLUSH
//  and S_MEAN setup states, a mean division (mode 0 only), the store walk,
//  a variance division (mode 0 only) and the output register
//  samples.ready is low from the last beat until the result is registered
//  no clearing pass after reset; the store is only read below the fill count
// ----------------------------------------------------------------------------
module weighted_mean_variance_core
    import wmv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic          cfg_data,
    wmv_in_if.sink        samples,
    wmv_out_if.source     results
);

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_FLUSH  = 6'b000010,
        S_MEAN   = 6'b000100,
        S_MDIV   = 6'b001000,
        S_PASS   = 6'b010000,
        S_VDIV   = 6'b100000
    } state_t;

    typedef struct packed {
        logic              ovf;
        logic [MEAN_W-1:0] mean;
    } mean_sat_t;

    typedef struct packed {
        logic             ovf;
        logic [VAR_W-1:0] value;
    } var_sat_t;

    function automatic mean_sat_t sat_mean(input logic neg, input logic [DIV_N_W-1:0] mag);
        mean_sat_t r;
        logic [DIV_N_W-1:0] lim;
        lim = neg ? DIV_N_W'(MEAN_NEG_MAX) : DIV_N_W'(MEAN_POS_MAX);
        if (mag > lim)
        begin
            r.ovf  = 1'b1;
            r.mean = neg ? MEAN_NEG_MAX : MEAN_POS_MAX;
        end
        else
        begin
            r.ovf  = 1'b0;
            r.mean = neg ? (~mag[MEAN_W-1:0] + 1'b1) : mag[MEAN_W-1:0];
        end
        return r;
    endfunction

    function automatic var_sat_t sat_var(input logic [DIV_N_W-1:0] x);
        var_sat_t r;
        if (|x[DIV_N_W-1:VAR_W])
        begin
            r.ovf   = 1'b1;
            r.value = '1;
        end
        else
        begin
            r.ovf   = 1'b0;
            r.value = x[VAR_W-1:0];
        end
        return r;
    endfunction

    // control state
    state_t               state_reg,      state_next;
    logic                 mode_cfg_reg,   mode_cfg_next;
    logic                 mode_reg,       mode_next;
    logic [CNT_W-1:0]     count_reg,      count_next;
    logic                 cap_reg,        cap_next;
    logic                 prod_vld_reg,   prod_vld_next;
    logic                 pass_start_reg, pass_start_next;
    logic                 pending_reg,    pending_next;
    logic                 out_valid_reg,  out_valid_next;
    logic signed [SUM_W-1:0] sum_reg,     sum_next;
    logic [TOTAL_W-1:0]   total_reg,      total_next;

    // payload
    logic signed [PROD_W:0]  prod_reg,    prod_next;
    logic [MEAN_W-1:0]    mean_reg,       mean_next;
    logic [VAR_W-1:0]     var_reg,        var_next;
    logic                 zero_reg,       zero_next;
    logic                 ovf_reg,        ovf_next;
    logic [MEAN_W-1:0]    out_mean_reg,   out_mean_next;
    logic [VAR_W-1:0]     out_var_reg,    out_var_next;
    logic                 out_zero_reg,   out_zero_next;
    logic                 out_ovf_reg,    out_ovf_next;

    logic                 accept;
    logic                 has_room;
    logic                 sum_neg;
    logic [SUM_W-1:0]     sum_mag;
    mean_sat_t            ms;
    var_sat_t             vs;

    store_wr_t            store_wr;
    pass_cmd_t            pass_cmd;
    div_cmd_t             div_cmd;
    logic                 pass_done;
    logic [ACC_W-1:0]     pass_acc;
    logic                 div_done;
    logic [DIV_N_W-1:0]   div_q;

    assign samples.ready = (state_reg == S_LOAD) && !pending_reg;
    assign accept        = samples.valid && samples.ready;
    assign has_room      = count_reg < CNT_W'(MAX_PAIRS);
    assign sum_neg       = sum_reg[SUM_W-1];
    assign sum_mag       = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
    assign prod_next     = $signed({1'b0, samples.weight}) * samples.sample_value;

    assign store_wr.en   = accept && has_room;
    assign store_wr.addr = count_reg[ADDR_W-1:0];
    assign store_wr.data = {samples.weight, samples.sample_value};

    assign pass_cmd.start = pass_start_reg;
    assign pass_cmd.count = count_reg;
    assign pass_cmd.mean  = mean_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_cfg_next   = cfg_write ? cfg_data : mode_cfg_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        prod_vld_next   = accept && has_room;
        pass_start_next = 1'b0;
        pending_next    = pending_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        sum_next        = sum_reg;
        total_next      = total_reg;
        mean_next       = mean_reg;
        var_next        = var_reg;
        zero_next       = zero_reg;
        ovf_next        = ovf_reg;
        out_mean_next   = out_mean_reg;
        out_var_next    = out_var_reg;
        out_zero_next   = out_zero_reg;
        out_ovf_next    = out_ovf_reg;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = DIV_N_W'(sum_mag);
        div_cmd.divisor  = total_reg;
        ms = sat_mean(sum_neg, DIV_N_W'(sum_mag >> FRAC_W));
        vs = sat_var(DIV_N_W'(pass_acc >> FRAC_W));

        if (prod_vld_reg)
        begin
            sum_next = sum_reg + SUM_W'(prod_reg);
        end

        if (accept)
        begin
            if (has_room)
            begin
                count_next = count_reg + 1'b1;
                total_next = total_reg + TOTAL_W'(samples.weight);
            end
            else
            begin
                cap_next = 1'b1;
            end
            if (samples.last_pair)
            begin
                mode_next  = mode_cfg_reg;
                state_next = S_FLUSH;
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                // result waiting for the output register
                if (pending_reg && (!out_valid_reg || results.ready))
                begin
                    out_mean_next  = mean_reg;
                    out_var_next   = var_reg;
                    out_zero_next  = zero_reg;
                    out_ovf_next   = ovf_reg;
                    out_valid_next = 1'b1;
                    pending_next   = 1'b0;
                    count_next     = '0;
                    sum_next       = '0;
                    total_next     = '0;
                    cap_next       = 1'b0;
                end
            end
            S_FLUSH:
            begin
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                ovf_next  = cap_reg;
                zero_next = 1'b0;
                if (!mode_reg && (total_reg == '0))
                begin
                    mean_next    = '0;
                    var_next     = '0;
                    zero_next    = 1'b1;
                    pending_next = 1'b1;
                    state_next   = S_LOAD;
                end
                else if (!mode_reg)
                begin
                    div_cmd.start = 1'b1;
                    state_next    = S_MDIV;
                end
                else
                begin
                    mean_next       = ms.mean;
                    ovf_next        = cap_reg | ms.ovf;
                    pass_start_next = 1'b1;
                    state_next      = S_PASS;
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    ms              = sat_mean(sum_neg, div_q);
                    mean_next       = ms.mean;
                    ovf_next        = ovf_reg | ms.ovf;
                    pass_start_next = 1'b1;
                    state_next      = S_PASS;
                end
            end
            S_PASS:
            begin
                if (pass_done)
                begin
                    if (!mode_reg)
                    begin
                        div_cmd.start    = 1'b1;
                        div_cmd.dividend = pass_acc;
                        state_next       = S_VDIV;
                    end
                    else
                    begin
                        var_next     = vs.value;
                        ovf_next     = ovf_reg | vs.ovf;
                        pending_next = 1'b1;
                        state_next   = S_LOAD;
                    end
                end
            end
            S_VDIV:
            begin
                if (div_done)
                begin
                    vs           = sat_var(div_q);
                    var_next     = vs.value;
                    ovf_next     = ovf_reg | vs.ovf;
                    pending_next = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            mode_cfg_reg   <= 1'b0;
            mode_reg       <= 1'b0;
            count_reg      <= '0;
            cap_reg        <= 1'b0;
            prod_vld_reg   <= 1'b0;
            pass_start_reg <= 1'b0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_reg        <= '0;
            total_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_cfg_reg   <= mode_cfg_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            prod_vld_reg   <= prod_vld_next;
            pass_start_reg <= pass_start_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
            sum_reg        <= sum_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        mean_reg     <= mean_next;
        var_reg      <= var_next;
        zero_reg     <= zero_next;
        ovf_reg      <= ovf_next;
        out_mean_reg <= out_mean_next;
        out_var_reg  <= out_var_next;
        out_zero_reg <= out_zero_next;
        out_ovf_reg  <= out_ovf_next;
    end

    wmv_pass u_pass (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (store_wr),
        .cmd   (pass_cmd),
        .done  (pass_done),
        .acc   (pass_acc)
    );

    wmv_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .done     (div_done),
        .quotient (div_q)
    );

    assign results.valid      = out_valid_reg;
    assign results.mean       = out_mean_reg;
    assign results.variance   = out_var_reg;
    assign results.zero_total = out_zero_reg;
    assign results.overflow   = out_ovf_reg;

endmodule

### hw/rtl/wmv_checker.sv
// ----------------------------------------------------------------------------
// wmv_checker
// Port-level checks of the weighted mean and variance core.
// ----------------------------------------------------------------------------
module wmv_checker
    import wmv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_last,
    input logic              out_valid,
    input logic              out_ready,
    input logic [MEAN_W-1:0] out_mean,
    input logic [VAR_W-1:0]  out_variance,
    input logic              out_zero_total
);

    // a result beat stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    // zero total forces zero results
    a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_zero_total |-> (out_mean == '0) && (out_variance == '0))
        else $error("zero total with nonzero results");

    // input stalls right after the last beat
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input accepted right after the last beat");

    // no new result right after the last beat
    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !$rose(out_valid))
        else $error("result appeared too early after the last beat");

endmodule

bind weighted_mean_variance_core wmv_checker u_wmv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (samples.valid),
    .in_ready       (samples.ready),
    .in_last        (samples.last_pair),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_mean       (results.mean),
    .out_variance   (results.variance),
    .out_zero_total (results.zero_total)
);
